// ----- rtl/wtg_pkg.sv -----
package wtg_pkg;

    localparam int PHASE_BITS       = 24;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_ADDR_W      = $clog2(SINE_TABLE_DEPTH);
    localparam int QTR_W            = SINE_ADDR_W - 2;
    localparam int SINE_QTR         = SINE_TABLE_DEPTH / 4;

    localparam int FREQ_W   = 14;
    localparam int LEN_W    = 16;
    localparam int VOL_W    = 8;
    localparam int WAVE_W   = 2;
    localparam int RATE_W   = 17;
    localparam int FADE_W   = 12;
    localparam int SAMPLE_W = 16;

    localparam int FREQ_LSB    = 0;
    localparam int LEN_LSB     = FREQ_LSB + FREQ_W;
    localparam int VOL_LSB     = LEN_LSB + LEN_W;
    localparam int WAVE_LSB    = VOL_LSB + VOL_W;
    localparam int IN_FIELDS_W = WAVE_LSB + WAVE_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = RATE_W;
    localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE_RATE = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_FADE_LENGTH = CFG_ADDR_W'(1);
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(22050);
    localparam logic [FADE_W-1:0] FADE_RESET = FADE_W'(220);

    // waveform magnitude, signed waveform value, multiplier and divider sizes
    localparam int MAG_W          = 16;
    localparam int WV_W           = MAG_W + 2;
    localparam int WAVE_FULL      = 32768;
    localparam int TRI_RISE_END   = 32768;
    localparam int TRI_FALL_END   = 98304;
    localparam int TRI_PERIOD     = 131072;
    localparam int TRI_PEAK2      = 65536;
    localparam int MUL_A_W        = MAG_W + VOL_W;
    localparam int MUL_B_W        = FADE_W;
    localparam int PROD_W         = MUL_A_W + MUL_B_W;
    localparam int ENV_SHIFT      = 9;
    localparam int DIV_DIVIDEND_W = FREQ_W + PHASE_BITS;
    localparam int DIV_DIVISOR_W  = RATE_W;
    localparam int DIV_CNT_W      = $clog2(DIV_DIVIDEND_W);

    typedef enum logic {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

    typedef enum logic [WAVE_W-1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_TRIANGLE = 2'd2,
        WAVE_SAWTOOTH = 2'd3
    } wave_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP_DIV,
        ST_MUL_VOL,
        ST_MUL_ENV,
        ST_SMP_DIV_LOAD,
        ST_SMP_DIV
    } state_t;

    typedef struct packed {
        logic start_tone;
        logic tick_go;
        logic tick_drop;
        logic load_step;
        logic mul_vol;
        logic mul_env;
        logic div_smp_start;
        logic load_out;
    } wtg_cmd_t;

    typedef struct packed {
        logic tick_ok;
        logic div_done;
        logic out_free;
    } wtg_status_t;

    typedef logic [MAG_W-1:0] sine_tab_t [SINE_QTR+1];

    // quarter-wave sine magnitude in Q15, Q28 Taylor series to x^15/15!
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t   tab;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] mag;
        longint      sum;
        int          j;
        for (j = 0; j <= SINE_QTR; j++) begin
            r    = 64'(j) << (32 - SINE_ADDR_W);
            x    = (r * 64'd421657428) >> 30;
            x2   = (x * x) >> 28;
            term = x;
            sum  = longint'(x);
            term = ((term * x2) >> 28) / 64'd6;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 28) / 64'd20;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 28) / 64'd42;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 28) / 64'd72;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 28) / 64'd110;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 28) / 64'd156;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 28) / 64'd210;
            sum  = sum - longint'(term);
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > (longint'(1) << 28)) begin
                sum = longint'(1) << 28;
            end
            mag = (64'(sum) + 64'd4096) >> 13;
            if (mag > 64'd32768) begin
                mag = 64'd32768;
            end
            tab[j] = mag[MAG_W-1:0];
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// ----- rtl/wtg_div.sv -----
module wtg_div import wtg_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [DIV_DIVIDEND_W-1:0] dividend,
    input  logic [DIV_DIVISOR_W-1:0]  divisor,
    output logic [DIV_DIVIDEND_W-1:0] quotient,
    output logic                      done
);

    logic [DIV_DIVIDEND_W-1:0] quo_reg;
    logic [DIV_DIVISOR_W-1:0]  rem_reg;
    logic [DIV_DIVISOR_W-1:0]  dsr_reg;
    logic [DIV_CNT_W-1:0]      cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [DIV_DIVISOR_W:0]    rem_shift;
    logic                      fits;
    logic [DIV_DIVISOR_W:0]    rem_sub;

    assign rem_shift = {rem_reg, quo_reg[DIV_DIVIDEND_W-1]};
    assign fits      = rem_shift >= {1'b0, dsr_reg};
    assign rem_sub   = rem_shift - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_DIVIDEND_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? rem_sub[DIV_DIVISOR_W-1:0] : rem_shift[DIV_DIVISOR_W-1:0];
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ----- rtl/wtg_datapath.sv -----
module wtg_datapath import wtg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  wtg_cmd_t              cmd,
    output wtg_status_t           status,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SAMPLE_W-1:0]   m_tdata,
    output logic                  m_tlast
);

    logic [RATE_W-1:0]     rate_reg;
    logic [FADE_W-1:0]     fade_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] step_reg;
    logic [LEN_W-1:0]      index_reg;
    logic [LEN_W-1:0]      length_reg;
    logic [VOL_W-1:0]      volume_reg;
    wave_t                 wave_reg;
    logic                  active_reg;

    logic [MAG_W-1:0]      mag_w_reg;
    logic                  neg_reg;
    logic [FADE_W-1:0]     num_reg;
    logic [FADE_W-1:0]     den_reg;
    logic                  last_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic                  out_valid_reg;
    logic [SAMPLE_W-1:0]   out_data_reg;
    logic                  out_last_reg;

    logic [SINE_ADDR_W-1:0]    k;
    logic [1:0]                quad;
    logic [QTR_W:0]            tab_idx;
    logic [MAG_W-1:0]          sine_mag;
    logic [PHASE_BITS:0]       phase_x2;
    logic [16:0]               q17;
    logic [15:0]               q16;
    logic [WV_W-1:0]           q17_ext;
    logic [WV_W-1:0]           w_val;
    logic [WV_W-1:0]           w_abs;
    logic                      w_neg;
    logic [LEN_W:0]            idx_plus_f;
    logic [FADE_W-1:0]         num_next;
    logic [FADE_W-1:0]         den_next;
    logic                      last_next;
    logic [MUL_A_W-1:0]        mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic [PROD_W-1:0]         mul_p;
    logic                      div_start;
    logic [DIV_DIVIDEND_W-1:0] div_dividend;
    logic [DIV_DIVISOR_W-1:0]  div_divisor;
    logic [DIV_DIVIDEND_W-1:0] div_quot;
    logic                      div_done;
    logic [SAMPLE_W-1:0]       q_s;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= RATE_RESET;
            fade_reg <= FADE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_SAMPLE_RATE: rate_reg <= cfg_wdata[RATE_W-1:0];
                CFG_FADE_LENGTH: fade_reg <= cfg_wdata[FADE_W-1:0];
                default: ;
            endcase
        end
    end

    // waveform from the current phase
    assign k        = phase_reg[PHASE_BITS-1 -: SINE_ADDR_W];
    assign quad     = k[SINE_ADDR_W-1 -: 2];
    assign tab_idx  = quad[0] ? ((QTR_W+1)'(SINE_QTR) - {1'b0, k[QTR_W-1:0]})
                              : {1'b0, k[QTR_W-1:0]};
    assign sine_mag = SINE_TAB[tab_idx];
    assign phase_x2 = {phase_reg, 1'b0};
    assign q17      = phase_x2[PHASE_BITS -: 17];
    assign q16      = phase_reg[PHASE_BITS-1 -: 16];
    assign q17_ext  = WV_W'(q17);

    always_comb begin
        unique case (wave_reg)
            WAVE_SINE: begin
                w_val = quad[1] ? (~WV_W'(sine_mag) + WV_W'(1)) : WV_W'(sine_mag);
            end
            WAVE_SQUARE: begin
                w_val = (!quad[1] && sine_mag != '0) ? WV_W'(WAVE_FULL)
                                                     : (~WV_W'(WAVE_FULL) + WV_W'(1));
            end
            WAVE_TRIANGLE: begin
                if (q17 < 17'(TRI_RISE_END)) begin
                    w_val = q17_ext;
                end else if (q17 < 17'(TRI_FALL_END)) begin
                    w_val = WV_W'(TRI_PEAK2) - q17_ext;
                end else begin
                    w_val = q17_ext - WV_W'(TRI_PERIOD);
                end
            end
            WAVE_SAWTOOTH: begin
                w_val = {{(WV_W-16){q16[15]}}, q16};
            end
            default: w_val = '0;
        endcase
    end

    assign w_neg = w_val[WV_W-1];
    assign w_abs = w_neg ? (~w_val + WV_W'(1)) : w_val;

    // fade envelope
    assign idx_plus_f = {1'b0, index_reg} + (LEN_W+1)'(fade_reg);
    assign last_next  = ({1'b0, index_reg} + (LEN_W+1)'(1)) == {1'b0, length_reg};

    always_comb begin
        priority if (fade_reg != '0 && index_reg < LEN_W'(fade_reg)) begin
            num_next = index_reg[FADE_W-1:0];
            den_next = fade_reg;
        end else if (fade_reg != '0 && idx_plus_f > {1'b0, length_reg}) begin
            num_next = FADE_W'(length_reg - index_reg);
            den_next = fade_reg;
        end else begin
            num_next = FADE_W'(1);
            den_next = FADE_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= '0;
            step_reg   <= '0;
            index_reg  <= '0;
            length_reg <= '0;
            volume_reg <= '0;
            wave_reg   <= WAVE_SINE;
            active_reg <= 1'b0;
        end else begin
            if (cmd.start_tone) begin
                length_reg <= s_tdata[LEN_LSB +: LEN_W];
                volume_reg <= s_tdata[VOL_LSB +: VOL_W];
                wave_reg   <= wave_t'(s_tdata[WAVE_LSB +: WAVE_W]);
                phase_reg  <= '0;
                index_reg  <= '0;
                active_reg <= s_tdata[LEN_LSB +: LEN_W] != '0;
            end
            if (cmd.load_step) begin
                step_reg <= (rate_reg == '0) ? '0 : div_quot[PHASE_BITS-1:0];
            end
            if (cmd.tick_drop) begin
                active_reg <= 1'b0;
            end
            if (cmd.tick_go) begin
                phase_reg <= phase_reg + step_reg;
                index_reg <= index_reg + LEN_W'(1);
                if (last_next) begin
                    active_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tick_go) begin
            mag_w_reg <= w_abs[MAG_W-1:0];
            neg_reg   <= w_neg;
            num_reg   <= num_next;
            den_reg   <= den_next;
            last_reg  <= last_next;
        end
        if (cmd.mul_vol || cmd.mul_env) begin
            prod_reg <= mul_p;
        end
    end

    // one multiplier for volume, then envelope numerator
    assign mul_a = cmd.mul_env ? prod_reg[MUL_A_W-1:0] : MUL_A_W'(mag_w_reg);
    assign mul_b = cmd.mul_env ? num_reg : MUL_B_W'(volume_reg);
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign div_start    = cmd.start_tone || cmd.div_smp_start;
    assign div_dividend = cmd.start_tone
                        ? {s_tdata[FREQ_LSB +: FREQ_W], PHASE_BITS'(0)}
                        : DIV_DIVIDEND_W'(prod_reg >> ENV_SHIFT);
    assign div_divisor  = cmd.start_tone ? rate_reg : DIV_DIVISOR_W'(den_reg);

    wtg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .done     (div_done)
    );

    assign q_s = div_quot[SAMPLE_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg <= neg_reg ? (~q_s + SAMPLE_W'(1)) : q_s;
            out_last_reg <= last_reg;
        end
    end

    assign status.tick_ok  = active_reg && (index_reg < length_reg);
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- rtl/wtg_ctrl.sv -----
module wtg_ctrl import wtg_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tuser,
    output logic        s_tready,
    input  wtg_status_t status,
    output wtg_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    op_t    op;

    assign op = op_t'(s_tuser);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (op == OP_START) begin
                        state_next = ST_STEP_DIV;
                    end else if (status.tick_ok) begin
                        state_next = ST_MUL_VOL;
                    end
                end
            end
            ST_STEP_DIV: begin
                if (status.div_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL_VOL:      state_next = ST_MUL_ENV;
            ST_MUL_ENV:      state_next = ST_SMP_DIV_LOAD;
            ST_SMP_DIV_LOAD: state_next = ST_SMP_DIV;
            ST_SMP_DIV: begin
                if (status.div_done && status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready       = 1'b1;
                cmd.start_tone = s_tvalid && (op == OP_START);
                cmd.tick_go    = s_tvalid && (op == OP_TICK) && status.tick_ok;
                cmd.tick_drop  = s_tvalid && (op == OP_TICK) && !status.tick_ok;
            end
            ST_STEP_DIV:     cmd.load_step = status.div_done;
            ST_MUL_VOL:      cmd.mul_vol = 1'b1;
            ST_MUL_ENV:      cmd.mul_env = 1'b1;
            ST_SMP_DIV_LOAD: cmd.div_smp_start = 1'b1;
            ST_SMP_DIV:      cmd.load_out = status.div_done && status.out_free;
            default: ;
        endcase
    end

endmodule

// ----- rtl/waveform_tone_generator_top.sv -----
// Tone generator: phase accumulator oscillator with a linear fade envelope.
// Input stream: s_tuser selects the item kind (0 start a tone, 1 one sample
// tick). On a start, s_tdata carries frequency, length, volume and waveform;
// on a tick it is ignored. Output stream: one signed 16-bit sample per tick
// of a playing tone, m_tlast high on the final sample. Ticks with no tone
// playing produce no transfer. sample_rate and fade_length are written on
// the cfg port; the user must write them only while the block is idle,
// since the block itself does not enforce this. A start occupies the
// block while the shared 38-step restoring divider forms the phase step.
// A tick passes twice through one shared multiplier, loads the divider,
// runs the 38 divider steps that apply the fade and then loads the output
// register once it is free; m_tvalid rises and s_tready returns in the
// same cycle, so the block takes no new item while a tick is in progress.
// Reset clears all tone state and the output valid flag and loads
// sample_rate 22050 and fade_length 220.
// When the receiver stalls, a finished sample waits in the output register;
// the block takes the next item meanwhile and holds its own next sample in
// the divider until the output register frees.
module waveform_tone_generator_top import wtg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [13:0] frequency_hz, [29:14] length_samples, [37:30] volume_level,
    // [39:38] wave_kind
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [0] operation
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [15:0] sample_value
    output logic [SAMPLE_W-1:0]   m_tdata,
    output logic                  m_tlast,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    wtg_cmd_t    cmd;
    wtg_status_t status;

    wtg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wtg_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- rtl/wtg_checker.sv -----
module wtg_checker import wtg_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [SAMPLE_W-1:0]   m_tdata,
    input logic                  m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output transfer changed while stalled");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser |=> !s_tready)
        else $error("start accepted without busy period");

    a_sample_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[SAMPLE_W-1:SAMPLE_W-2] == 2'b00
                   || m_tdata[SAMPLE_W-1:SAMPLE_W-2] == 2'b11))
        else $error("sample magnitude out of range");

    a_no_early_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("sample appeared right after an input transfer");

endmodule

bind waveform_tone_generator_top wtg_checker u_wtg_checker (.*);

// ----- tb/sv/testbench.sv -----
module testbench import wtg_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_A = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_B = CFG_ADDR_W'(3);
    localparam longint unsigned HALF_PI_Q28 = 64'd421657428;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 60;
    localparam int MAX_REPORTS   = 50;

    typedef struct {
        logic [SAMPLE_W-1:0] value;
        logic                last;
    } tone_sample_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [SAMPLE_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // oscillator state mirrored from the block
    logic [RATE_W-1:0]     rate_cfg = RATE_RESET;
    logic [FADE_W-1:0]     fade_cfg = FADE_RESET;
    logic [PHASE_BITS-1:0] osc_phase = '0;
    logic [PHASE_BITS-1:0] osc_step  = '0;
    logic [LEN_W-1:0]      smp_idx   = '0;
    logic [LEN_W-1:0]      tone_len  = '0;
    logic [VOL_W-1:0]      tone_vol  = '0;
    wave_t                 tone_shape = WAVE_SINE;
    logic                  tone_on   = 1'b0;

    tone_sample_t pending_samples[$];
    int unsigned  counted_items = 0;
    int           error_count   = 0;
    int           cycle_count   = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           stall_cycles  = 0;

    waveform_tone_generator_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%0t: %s", $time, what);
        end
    endtask

    function automatic int sine_q15(input logic [SINE_ADDR_W-1:0] k);
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] mag;
        longint      sum;
        r = 64'(k[QTR_W-1:0]) << (30 - QTR_W);
        if (k[SINE_ADDR_W-2]) begin
            r = (64'd1 << 30) - r;
        end
        x    = (r * HALF_PI_Q28) >> 30;
        x2   = (x * x) >> 28;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 28) / 64'(2 * n * (2 * n + 1));
            if (n % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > (longint'(1) << 28)) begin
            sum = longint'(1) << 28;
        end
        mag = (64'(sum) + 64'd4096) >> 13;
        if (mag > 64'd32768) begin
            mag = 64'd32768;
        end
        return k[SINE_ADDR_W-1] ? -int'(mag) : int'(mag);
    endfunction

    function automatic int tone_wave_value();
        logic [15:0]            q16;
        logic [16:0]            q17;
        logic [SINE_ADDR_W-1:0] k;
        int                     s;
        q16 = osc_phase[PHASE_BITS-1 -: 16];
        q17 = osc_phase[PHASE_BITS-1 -: 17];
        k   = osc_phase[PHASE_BITS-1 -: SINE_ADDR_W];
        case (tone_shape)
            WAVE_SINE: begin
                return sine_q15(k);
            end
            WAVE_SQUARE: begin
                s = sine_q15(k);
                return (s > 0) ? 32768 : -32768;
            end
            WAVE_TRIANGLE: begin
                if (q17 < TRI_RISE_END) begin
                    return int'(q17);
                end else if (q17 < TRI_FALL_END) begin
                    return TRI_PEAK2 - int'(q17);
                end
                return int'(q17) - TRI_PERIOD;
            end
            default: begin
                return int'($signed(q16));
            end
        endcase
    endfunction

    function automatic void predict_tone(input op_t op, input logic [IN_DATA_W-1:0] data);
        logic [FREQ_W-1:0] freq;
        longint            idx;
        longint            len;
        longint            fade;
        longint            num;
        longint            den;
        longint            prod;
        tone_sample_t      smp;
        freq = data[FREQ_LSB +: FREQ_W];
        if (op == OP_START) begin
            osc_step = (rate_cfg == 0) ? '0
                     : PHASE_BITS'((64'(freq) << PHASE_BITS) / 64'(rate_cfg));
            tone_len   = data[LEN_LSB +: LEN_W];
            tone_vol   = data[VOL_LSB +: VOL_W];
            tone_shape = wave_t'(data[WAVE_LSB +: WAVE_W]);
            osc_phase  = '0;
            smp_idx    = '0;
            tone_on    = (tone_len != 0);
            counted_items++;
            return;
        end
        if (!tone_on || smp_idx >= tone_len) begin
            tone_on = 1'b0;
            counted_items++;
            return;
        end
        idx  = longint'(smp_idx);
        len  = longint'(tone_len);
        fade = longint'(fade_cfg);
        num  = 1;
        den  = 1;
        if (fade != 0) begin
            if (idx < fade) begin
                num = idx;
                den = fade;
            end else if (idx > len - fade) begin
                num = len - idx;
                den = fade;
            end
        end
        prod = longint'(tone_wave_value()) * 64 * longint'(tone_vol) * num;
        prod = prod / (32768 * den);
        smp.value = prod[SAMPLE_W-1:0];
        smp.last  = (smp_idx + 1 == tone_len);
        pending_samples.insert(pending_samples.size(), smp);
        osc_phase = osc_phase + osc_step;
        smp_idx   = smp_idx + 1'b1;
        if (smp.last) begin
            tone_on = 1'b0;
        end
        counted_items++;
    endfunction

    always @(posedge aclk) begin : sample_check
        tone_sample_t want;
        if (m_tvalid === 1'b1 && m_tready) begin
            if (pending_samples.size() == 0) begin
                report_mismatch($sformatf("unexpected sample %h last %b", m_tdata, m_tlast));
            end else begin
                want = pending_samples.pop_front();
                if (m_tdata !== want.value) begin
                    report_mismatch($sformatf("sample %h, expected %h", m_tdata, want.value));
                end
                if (m_tlast !== want.last) begin
                    report_mismatch($sformatf("tlast %b, expected %b", m_tlast, want.last));
                end
            end
        end
    end

    always @(posedge aclk) begin : ready_drive
        if (stall_cycles > 0) begin
            stall_cycles--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(input op_t op, input logic [IN_DATA_W-1:0] data);
        int unsigned gap;
        gap = 0;
        if (send_idle_pct != 0) begin
            if ($urandom_range(15) == 0) begin
                gap = $urandom_range(60, 1);
            end else begin
                while ($urandom_range(99) < send_idle_pct) begin
                    gap++;
                end
            end
        end
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        predict_tone(op, data);
    endtask

    task automatic send_start(input logic [FREQ_W-1:0] freq, input logic [LEN_W-1:0] len,
                              input logic [VOL_W-1:0] vol, input wave_t wave);
        send_item(OP_START, IN_DATA_W'({wave, vol, len, freq}));
    endtask

    task automatic send_tick();
        send_item(OP_TICK, IN_DATA_W'({$urandom, $urandom}));
    endtask

    // drop valid, drain expected samples, then let a start or a silent tick finish
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_samples.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(input logic [RATE_W-1:0] rate, input logic [FADE_W-1:0] fade);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_SAMPLE_RATE;
        cfg_wdata <= CFG_DATA_W'(rate);
        @(posedge aclk);
        cfg_addr  <= CFG_FADE_LENGTH;
        cfg_wdata <= CFG_DATA_W'(fade);
        @(posedge aclk);
        cfg_addr  <= CFG_SPARE_A;
        cfg_wdata <= CFG_DATA_W'($urandom);
        @(posedge aclk);
        cfg_addr  <= CFG_SPARE_B;
        cfg_wdata <= CFG_DATA_W'($urandom);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        rate_cfg = rate;
        fade_cfg = fade;
    endtask

    task automatic test_no_tone();
        send_tick();
        send_start(FREQ_W'(440), LEN_W'(0), VOL_W'(200), WAVE_SINE);
        send_tick();
    endtask

    task automatic test_waveforms();
        send_start(FREQ_W'(1), LEN_W'(3), VOL_W'(255), WAVE_SINE);
        repeat (4) send_tick();
        send_start(FREQ_W'(16383), LEN_W'(2), VOL_W'(0), WAVE_SQUARE);
        repeat (2) send_tick();
        send_start(FREQ_W'(5000), LEN_W'(3), VOL_W'(128), WAVE_TRIANGLE);
        repeat (3) send_tick();
        send_start(FREQ_W'(11025), LEN_W'(4), VOL_W'(255), WAVE_SAWTOOTH);
        repeat (4) send_tick();
    endtask

    task automatic test_retrigger();
        send_start(FREQ_W'(700), LEN_W'(65535), VOL_W'(255), WAVE_TRIANGLE);
        repeat (2) send_tick();
        send_start(FREQ_W'(16383), LEN_W'(65535), VOL_W'(255), WAVE_SAWTOOTH);
        repeat (2) send_tick();
    endtask

    task automatic test_backpressure();
        wait_idle();
        write_config(RATE_W'(48000), FADE_W'(8));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_start(FREQ_W'(1000), LEN_W'(40), VOL_W'(200), WAVE_SINE);
        stall_cycles = 600;
        repeat (30) send_tick();
        wait_idle();
    endtask

    task automatic run_random_phase(input int sender_idle, input int receiver_stall,
                                    input logic [RATE_W-1:0] rate,
                                    input logic [FADE_W-1:0] fade, input int unsigned quota);
        int unsigned base;
        int unsigned len;
        int unsigned ticks;
        int unsigned choice;
        wait_idle();
        write_config(rate, fade);
        send_idle_pct = sender_idle;
        recv_idle_pct = receiver_stall;
        base = counted_items;
        while (counted_items - base < quota) begin
            choice = $urandom_range(9);
            if (choice == 0) begin
                if ($urandom_range(1) == 1) begin
                    send_tick();
                end else begin
                    send_start(FREQ_W'($urandom), LEN_W'(0), VOL_W'($urandom),
                               wave_t'($urandom_range(3)));
                end
            end else begin
                len = ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(60, 1);
                send_start(FREQ_W'($urandom), LEN_W'(len), VOL_W'($urandom),
                           wave_t'($urandom_range(3)));
                ticks = len + $urandom_range(2);
                if (choice == 1) begin
                    ticks = $urandom_range(ticks);
                end
                if (ticks > 80) begin
                    ticks = $urandom_range(80, 1);
                end
                repeat (ticks) send_tick();
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_no_tone();
        test_waveforms();
        test_retrigger();
        test_backpressure();
        run_random_phase(0, 0, RATE_W'(8000), FADE_W'(1), 340);
        run_random_phase(61, 0, RATE_W'(96000), FADE_W'(4095), 340);
        run_random_phase(0, 61, RATE_W'(44100), FADE_W'(3), 340);
        run_random_phase(33, 33, RATE_W'(0), FADE_W'(0), 340);
        run_random_phase(0, 0, RATE_W'(131071), FADE_W'(16), 340);
        wait_idle();
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
